// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/u8u16_pkg.sv =====
// Types, constants and the unit-expansion function of the UTF-8 decoder.
// Depends on nothing; used by every module of the block.
package u8u16_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int UNIT_W = 21;
    localparam int SLOTS  = 3;

    localparam logic [31:0] MAX_CODE   = 32'h0010_FFFF;
    localparam logic [31:0] BMP_TOP    = 32'h0000_FFFF;
    localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;
    localparam logic [31:0] SURR_LO    = 32'h0000_D800;
    localparam logic [31:0] SURR_END   = 32'h0000_E000;
    localparam logic [UNIT_W-1:0] HIGH_SURR = 21'h00_D800;
    localparam logic [UNIT_W-1:0] LOW_SURR  = 21'h00_DC00;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last_of_run;
    } out_item_t;

    // Units of one code point: zero, one or two
    typedef struct packed {
        logic [1:0]        cnt;
        logic [UNIT_W-1:0] u0;
        logic [UNIT_W-1:0] u1;
    } code_units_t;

    // One queue entry: all units caused by one byte, cnt in 1..3
    typedef struct packed {
        logic [1:0]                  cnt;
        logic [SLOTS-1:0][UNIT_W-1:0] units;
    } entry_t;

    function automatic code_units_t expand_code(input logic [31:0] cp, input logic wide);
        code_units_t r;
        logic [31:0] v;
        r  = '0;
        v  = cp - SUPP_BASE;
        if (cp > MAX_CODE) begin
            r.cnt = 2'd0;
        end else if (wide) begin
            r.cnt = 2'd1;
            r.u0  = cp[UNIT_W-1:0];
        end else if (cp > BMP_TOP) begin
            r.cnt = 2'd2;
            r.u0  = HIGH_SURR | {11'd0, v[19:10]};
            r.u1  = LOW_SURR | {11'd0, cp[9:0]};
        end else if (cp < SURR_LO || cp >= SURR_END) begin
            r.cnt = 2'd1;
            r.u0  = cp[UNIT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/u8u16_front.sv =====
// Front end: takes bytes, builds the code point and packs the resulting units.
// Depends on u8u16_pkg; pushes entries into u8u16_fifo.
module u8u16_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  u8u16_pkg::in_item_t in_data,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output u8u16_pkg::entry_t   q_entry
);
    import u8u16_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic        pend_reg, pend_next;
    logic        wide_reg;
    logic        accept;
    logic        is_cont;
    logic [7:0]  b;
    code_units_t ua, ub;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.byte_value;
    assign is_cont  = (b[7:6] == 2'b10);

    always_comb
    begin
        if (b[7] == 1'b0) begin
            acc_next = {24'd0, b};
        end else if (is_cont) begin
            acc_next = {acc_reg[25:0], b[5:0]};
        end else if (b[5] == 1'b0) begin
            acc_next = {27'd0, b[4:0]};
        end else if (b[4] == 1'b0) begin
            acc_next = {28'd0, b[3:0]};
        end else begin
            acc_next = {29'd0, b[2:0]};
        end
    end

    // Pending code flushes ahead of a lead byte; the new one flushes at end of string
    always_comb
    begin
        ua = '0;
        ub = '0;
        if (!is_cont && pend_reg) begin
            ua = expand_code(acc_reg, wide_reg);
        end
        if (in_data.end_of_string) begin
            ub = expand_code(acc_next, wide_reg);
        end
    end

    always_comb
    begin
        q_entry = '0;
        case (ua.cnt)
            2'd1:
            begin
                q_entry.units[0] = ua.u0;
                q_entry.units[1] = ub.u0;
                q_entry.units[2] = ub.u1;
            end
            2'd2:
            begin
                q_entry.units[0] = ua.u0;
                q_entry.units[1] = ua.u1;
                q_entry.units[2] = ub.u0;
            end
            default:
            begin
                q_entry.units[0] = ub.u0;
                q_entry.units[1] = ub.u1;
                q_entry.units[2] = '0;
            end
        endcase
        q_entry.cnt = ua.cnt + ub.cnt;
    end

    assign q_push = accept && (q_entry.cnt != 2'd0);

    always_comb
    begin
        pend_next = !in_data.end_of_string;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg  <= '0;
            pend_reg <= 1'b0;
            wide_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                wide_reg <= cfg_data;
            end
            if (accept) begin
                acc_reg  <= in_data.end_of_string ? 32'd0 : acc_next;
                pend_reg <= pend_next;
            end
        end
    end

endmodule

// ===== hdl/u8u16_fifo.sv =====
// Short entry queue between the front end and the output sequencer.
// Depends on u8u16_pkg for the entry type.
module u8u16_fifo #(
    parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u8u16_pkg::entry_t wr_entry,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output u8u16_pkg::entry_t rd_entry
);
    import u8u16_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/u8u16_back.sv =====
// Output sequencer: walks the units of the head entry into the output register.
// Depends on u8u16_pkg; pops entries from u8u16_fifo.
module u8u16_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  u8u16_pkg::entry_t    q_entry,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8u16_pkg::out_item_t out_data
);
    import u8u16_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;
    logic       load;
    logic       is_last;

    assign load      = !q_empty && (!out_valid_reg || out_ready);
    assign is_last   = (idx_reg == q_entry.cnt - 2'd1);
    assign q_pop     = load && is_last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg.unit        <= q_entry.units[idx_reg];
            out_reg.last_of_run <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? 2'd0 : idx_reg + 2'd1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder top level: front end, entry queue, output sequencer.
// Depends on u8u16_pkg, u8u16_front, u8u16_fifo and u8u16_back.
//
// Usage:
//   in_*  : one UTF-8 byte per transfer, end_of_string marks the final byte.
//   out_* : one UTF-16 unit (or whole code point when wide) per transfer;
//           last_of_run marks the final unit caused by one input byte.
//   cfg_* : writes wide_units; always ready, write only while idle.
// Throughput: one byte per cycle while each byte yields at most one unit and out_ready stays high.
//   The output register moves one unit per cycle while out_ready is high, so a byte
//   that yields two or three units holds its queue entry until all are loaded; the
//   entry queue (QUEUE_DEPTH entries) lets the front keep taking bytes meanwhile.
// Path: a byte's entry is written into the entry queue, and its units are then
//   loaded from the queue head into the output register.
// Reset clears the code accumulator, the pending flag, wide_units, the queue
//   and the output valid flag. When the receiver stalls, the output holds and
//   in_ready drops once the queue is full.
module utf8_to_utf16_decoder #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  u8u16_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8u16_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    import u8u16_pkg::*;

    logic   q_push, q_full, q_pop, q_empty;
    entry_t wr_entry, rd_entry;

    assign cfg_ready = 1'b1;

    u8u16_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (wr_entry)
    );

    u8u16_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .rd_entry (rd_entry)
    );

    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (rd_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/u8u16_checker.sv =====
// Port-level checks of the UTF-8 decoder, bound to the top level.
// Depends on u8u16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input u8u16_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input u8u16_pkg::out_item_t out_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic                 cfg_data
);
    import u8u16_pkg::*;

    logic wide_reg;
    logic high_surr;

    // Track the mode from config transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wide_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            wide_reg <= cfg_data;
        end
    end

    assign high_surr = (out_data.unit[20:10] == 11'b00000110110);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `ASSERT_IMPL(a_unit_range, clk, rst_n, out_valid, ({11'd0, out_data.unit} <= MAX_CODE))
    `ASSERT_IMPL(a_utf16_width, clk, rst_n, out_valid && !wide_reg, out_data.unit[20:16] == 5'd0)
    `ASSERT_IMPL(a_pair_split, clk, rst_n, out_valid && !wide_reg && high_surr, !out_data.last_of_run)

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_chk (.*);

// ===== sim/testbench.sv =====
// Self-checking bench for utf8_to_utf16_decoder: drives UTF-8 bytes, predicts units.
// Depends on u8u16_pkg (port struct types) and the decoder RTL.
`timescale 1ns / 1ps

module testbench;

    import u8u16_pkg::in_item_t;
    import u8u16_pkg::out_item_t;

    localparam logic [31:0] CODE_LIMIT  = 32'h0010_FFFF;
    localparam logic [31:0] PLANE_TOP   = 32'h0000_FFFF;
    localparam logic [31:0] PLANE1_BASE = 32'h0001_0000;
    localparam logic [31:0] SURR_FIRST  = 32'h0000_D800;
    localparam logic [31:0] SURR_LAST   = 32'h0000_DFFF;
    localparam logic [20:0] HI_BASE     = 21'h00_D800;
    localparam logic [20:0] LO_BASE     = 21'h00_DC00;
    localparam int          MAX_REPORTS = 10;

    // Tracks the code point being assembled and the units still owed by the decoder
    class unit_ledger;
        logic [31:0] cp_build;
        bit          cp_open;
        bit          wide;
        out_item_t   batch[$];
        out_item_t   units_due[$];
        int          errors;

        function new();
            cp_build = '0;
            cp_open  = 1'b0;
            wide     = 1'b0;
            errors   = 0;
        endfunction

        function void set_wide(bit w);
            wide = w;
        endfunction

        function int outstanding();
            return units_due.size();
        endfunction

        function void issue_units(logic [31:0] cp);
            out_item_t   u;
            logic [31:0] off;
            u.last_of_run = 1'b0;
            off = cp - PLANE1_BASE;
            if (cp > CODE_LIMIT)
                return;
            if (wide || (cp <= PLANE_TOP && (cp < SURR_FIRST || cp > SURR_LAST))) begin
                u.unit = cp[20:0];
                batch.push_back(u);
            end else if (cp > PLANE_TOP) begin
                u.unit = HI_BASE + 21'(off >> 10);
                batch.push_back(u);
                u.unit = LO_BASE + 21'(cp & 32'h3FF);
                batch.push_back(u);
            end
        endfunction

        function void note_byte(in_item_t item);
            logic [7:0] b;
            b = item.byte_value;
            batch.delete();
            // a lead byte closes the code point in progress
            if (b[7:6] != 2'b10 && cp_open)
                issue_units(cp_build);
            if (!b[7])
                cp_build = {24'd0, b};
            else if (!b[6])
                cp_build = {cp_build[25:0], b[5:0]};
            else if (!b[5])
                cp_build = {27'd0, b[4:0]};
            else if (!b[4])
                cp_build = {28'd0, b[3:0]};
            else
                cp_build = {29'd0, b[2:0]};
            cp_open = 1'b1;
            if (item.end_of_string) begin
                issue_units(cp_build);
                cp_build = '0;
                cp_open  = 1'b0;
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last_of_run = 1'b1;
            foreach (batch[i])
                units_due.push_back(batch[i]);
        endfunction

        function void check_unit(out_item_t got);
            out_item_t want;
            if (units_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unit %h last %b arrived with nothing owed",
                             got.unit, got.last_of_run);
                return;
            end
            want = units_due.pop_front();
            if (got.unit !== want.unit || got.last_of_run !== want.last_of_run) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unit exp %h last %b, got %h last %b",
                             want.unit, want.last_of_run, got.unit, got.last_of_run);
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    int         send_idle = 0;
    int         recv_idle = 0;
    unit_ledger ledger = new();

    utf8_to_utf16_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sample the output transfer, then pick the next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ledger.check_unit(out_data);
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        in_item_t item;
        item.byte_value    = b;
        item.end_of_string = eos;
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        ledger.note_byte(item);
    endtask

    // Drain the decoder, then transfer one wide_units write
    task automatic write_wide(input logic w);
        in_valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ledger.set_wide(w);
    endtask

    // Mostly well-formed sequences with random payload bits; some truncated, some noise
    task automatic send_random(input int count);
        int         sent;
        int         kind;
        int         len;
        logic [7:0] seq[4];
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            len  = $urandom_range(4, 1);
            case (len)
                1: seq[0] = 8'($urandom_range(127, 1));
                2: seq[0] = 8'hC0 | 8'($urandom_range(31));
                3: seq[0] = 8'hE0 | 8'($urandom_range(15));
                default: seq[0] = 8'hF0 | 8'($urandom_range(15));
            endcase
            for (int i = 1; i < 4; i++)
                seq[i] = 8'h80 | 8'($urandom_range(63));
            if (kind < 15) begin
                len    = 1;
                seq[0] = 8'($urandom_range(255, 1));
            end else if (kind < 25 && len > 1) begin
                len = $urandom_range(len - 1, 1);
            end
            for (int i = 0; i < len; i++)
                send_byte(seq[i], (i == len - 1) && ($urandom_range(5) == 0));
            sent += len;
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 26;
        recv_idle = 63;
        write_wide(1'b0);
        // two-, three- and four-byte forms; pending pair plus final byte gives three units
        send_byte(8'hC3, 0); send_byte(8'hA9, 0);
        send_byte(8'hE2, 0); send_byte(8'h82, 0); send_byte(8'hAC, 0);
        send_byte(8'hF0, 0); send_byte(8'h9F, 0); send_byte(8'h98, 0); send_byte(8'h80, 0);
        send_byte(8'h7F, 1);
        // lone surrogate is dropped, zero byte is a lead
        send_byte(8'hED, 0); send_byte(8'hA0, 0); send_byte(8'h80, 0);
        send_byte(8'h00, 1);
        // stray continuation after an end, then overlong growth past the limit
        send_byte(8'hBF, 0); send_byte(8'hFF, 0);
        send_byte(8'hBF, 0); send_byte(8'hBF, 0); send_byte(8'hBF, 1);
        // top code point, then the first value above it
        send_byte(8'hF4, 0); send_byte(8'h8F, 0); send_byte(8'hBF, 0); send_byte(8'hBF, 0);
        send_byte(8'hF4, 0); send_byte(8'h90, 0); send_byte(8'h80, 0); send_byte(8'h80, 1);
        send_random(75);

        send_idle = 63;
        recv_idle = 26;
        write_wide(1'b1);
        // surrogate value passes as a whole code point
        send_byte(8'hED, 0); send_byte(8'hA0, 0); send_byte(8'h80, 1);
        send_random(75);

        send_idle = 0;
        recv_idle = 0;
        write_wide(1'b0);
        send_random(40);
        write_wide(1'b1);
        send_random(40);

        in_valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (ledger.errors == 0 && ledger.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
